FILE: rtl/assert_macros.svh
// Assertion macros used by serpent_block_cipher.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

FILE: rtl/spc_pkg.sv
// Package for the Serpent cipher: types, constants, S-box and transform functions.
// No dependencies.
`default_nettype none
package spc_pkg;
  localparam int ROUND_COUNT = 32;
  localparam int KEY_ROUNDS  = ROUND_COUNT + 1;
  localparam int RK_AW       = 6;
  localparam int PRE_COUNT   = 4 * KEY_ROUNDS;
  localparam int PRE_CW      = 8;
  localparam logic [31:0] PHI_CONST = 32'h9e3779b9;
  localparam logic [2:0] CFG_REG_COUNT = 3'd4;

  typedef struct packed {
    logic        op;
    logic [31:0] in_word0;
    logic [31:0] in_word1;
    logic [31:0] in_word2;
    logic [31:0] in_word3;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
  } cfg_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_RUN,
    ST_DONE
  } ctl_state_t;

  // Round key store write port
  typedef struct packed {
    logic              we;
    logic [RK_AW-1:0]  addr;
    logic [127:0]      data;
  } rk_wr_t;

  // Each row holds entry n of the box in bits 4n+3..4n
  function automatic logic [3:0] sbox_fwd(input logic [2:0] box, input logic [3:0] n);
    logic [63:0] row;
    unique case (box)
      3'd0: row = 64'hc90724deb56a1f83;
      3'd1: row = 64'h43d68eb1a50972cf;
      3'd2: row = 64'h25b04e1dfac39768;
      3'd3: row = 64'he57a421d369c8bf0;
      3'd4: row = 64'hd7e9a4526b0c38f1;
      3'd5: row = 64'h176d8e30c9a4b25f;
      3'd6: row = 64'h0a3df19eb6485c27;
      default: row = 64'h6539ac47b28e0fd1;
    endcase
    return row[n*4 +: 4];
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [2:0] box, input logic [3:0] n);
    logic [3:0] r;
    r = 4'd0;
    for (int v = 0; v < 16; v++) begin
      if (sbox_fwd(box, 4'(v)) == n) r = 4'(v);
    end
    return r;
  endfunction

  function automatic logic [127:0] sbox_slice(input logic [2:0] box, input logic [127:0] w,
                                              input logic inv);
    logic [127:0] r;
    logic [3:0] nib, v;
    r = '0;
    for (int j = 0; j < 32; j++) begin
      nib = {w[96+j], w[64+j], w[32+j], w[j]};
      v = inv ? sbox_inv(box, nib) : sbox_fwd(box, nib);
      r[j] = v[0]; r[32+j] = v[1]; r[64+j] = v[2]; r[96+j] = v[3];
    end
    return r;
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Words packed as {x3,x2,x1,x0}
  function automatic logic [127:0] lin_fwd(input logic [127:0] s);
    logic [31:0] x0, x1, x2, x3;
    x0 = s[31:0]; x1 = s[63:32]; x2 = s[95:64]; x3 = s[127:96];
    x0 = rol(x0, 13); x2 = rol(x2, 3);
    x1 = x1 ^ x0 ^ x2; x3 = x3 ^ x2 ^ (x0 << 3);
    x1 = rol(x1, 1); x3 = rol(x3, 7);
    x0 = x0 ^ x1 ^ x3; x2 = x2 ^ x3 ^ (x1 << 7);
    x0 = rol(x0, 5); x2 = rol(x2, 22);
    return {x3, x2, x1, x0};
  endfunction

  function automatic logic [127:0] lin_inv(input logic [127:0] s);
    logic [31:0] x0, x1, x2, x3;
    x0 = s[31:0]; x1 = s[63:32]; x2 = s[95:64]; x3 = s[127:96];
    x2 = rol(x2, 10); x0 = rol(x0, 27);
    x2 = x2 ^ x3 ^ (x1 << 7); x0 = x0 ^ x1 ^ x3;
    x3 = rol(x3, 25); x1 = rol(x1, 31);
    x3 = x3 ^ x2 ^ (x0 << 3); x1 = x1 ^ x0 ^ x2;
    x2 = rol(x2, 29); x0 = rol(x0, 19);
    return {x3, x2, x1, x0};
  endfunction
endpackage
`default_nettype wire

FILE: rtl/spc_rk_ram.sv
// Round key memory: one write port, one registered read port.
// Depends on spc_pkg.
`default_nettype none
module spc_rk_ram (
  input  wire logic                      clk,
  input  wire spc_pkg::rk_wr_t           wr,
  input  wire logic [spc_pkg::RK_AW-1:0] rd_addr,
  output logic [127:0]                   rd_data
);
  logic [127:0] mem [spc_pkg::KEY_ROUNDS];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: rtl/spc_key_sched.sv
// Key schedule: one prekey word per cycle, a round key written every four words.
// Depends on spc_pkg.
`default_nettype none
module spc_key_sched (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [255:0]      key,
  output logic                   busy,
  output spc_pkg::rk_wr_t        wr
);
  logic [255:0] win_r, win_nxt;
  logic [spc_pkg::PRE_CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [31:0] w;
  logic [5:0] ridx;

  // Next prekey word from the sliding window
  assign w = spc_pkg::rol(win_r[31:0] ^ win_r[127:96] ^ win_r[191:160] ^ win_r[255:224]
                          ^ spc_pkg::PHI_CONST ^ 32'(cnt_r), 11);
  assign ridx = cnt_r[7:2];

  always_comb begin
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    wr.we = 1'b0;
    wr.addr = ridx;
    wr.data = spc_pkg::sbox_slice(3'(3'd3 - ridx[2:0]), {w, win_r[255:160]}, 1'b0);
    if (start) begin
      win_nxt = key;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      win_nxt = {w, win_r[255:32]};
      cnt_nxt = cnt_r + 1'b1;
      wr.we = (cnt_r[1:0] == 2'd3);
      if (cnt_r == 8'(spc_pkg::PRE_COUNT - 1)) busy_nxt = 1'b0;
    end
  end

  // Hold window, count and busy flag
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  assign busy = busy_r;
endmodule
`default_nettype wire

FILE: rtl/serpent_block_cipher.sv
// Serpent-256 block cipher, round keys held in a 33-entry memory.
// An accepted item reads its first round key ahead, then runs one round a cycle.
// One item at a time: a new item is taken only in idle, after the last result is taken.
// A key write runs a key expansion; the first item after reset with no key write waits for one.
// Reset (synchronous, rst_n low) clears control state and the key registers.
`default_nettype none
`include "assert_macros.svh"
module serpent_block_cipher (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire spc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output spc_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire spc_pkg::cfg_item_t cfg_data
);
  spc_pkg::ctl_state_t st_r, st_nxt;
  logic [255:0] key_r;
  logic valid_r, valid_nxt;
  logic ks_start, ks_busy;
  spc_pkg::rk_wr_t ks_wr;
  logic [spc_pkg::RK_AW-1:0] rd_addr;
  logic [127:0] rk;
  logic [127:0] s_r, s_nxt;
  logic op_r, op_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic pend_r, pend_nxt;
  logic cfg_hit;
  logic [127:0] mix, sb;

  assign cfg_ready = (st_r == spc_pkg::ST_IDLE) && !ks_busy && !pend_r;
  assign cfg_hit = cfg_valid && cfg_ready && (cfg_data.cfg_index < spc_pkg::CFG_REG_COUNT);

  // Hold key registers
  always_ff @(posedge clk) begin
    if (!rst_n) key_r <= '0;
    else if (cfg_hit) key_r[cfg_data.cfg_index[1:0]*64 +: 64] <= cfg_data.cfg_data;
  end

  spc_key_sched u_ks (.clk(clk), .rst_n(rst_n), .start(ks_start),
                      .key(cfg_hit ? (key_r & ~(256'hffffffffffffffff
                                                << (cfg_data.cfg_index[1:0]*64)))
                                     | (256'(cfg_data.cfg_data) << (cfg_data.cfg_index[1:0]*64))
                                   : key_r),
                      .busy(ks_busy), .wr(ks_wr));

  spc_rk_ram u_ram (.clk(clk), .wr(ks_wr), .rd_addr(rd_addr), .rd_data(rk));

  assign mix = s_r ^ rk;
  assign in_ready = (st_r == spc_pkg::ST_IDLE) && !ks_busy && !pend_r && !cfg_valid;

  // Round datapath and control
  always_comb begin
    st_nxt = st_r;
    s_nxt = s_r;
    op_nxt = op_r;
    rnd_nxt = rnd_r;
    pend_nxt = pend_r;
    valid_nxt = valid_r;
    ks_start = 1'b0;
    sb = '0;
    rd_addr = rnd_r;
    out_valid = (st_r == spc_pkg::ST_DONE);
    unique case (st_r)
      spc_pkg::ST_IDLE: begin
        if (cfg_hit) begin
          ks_start = 1'b1;
          valid_nxt = 1'b1;
        end else if (in_valid && in_ready) begin
          s_nxt = {in_data.in_word3, in_data.in_word2, in_data.in_word1, in_data.in_word0};
          op_nxt = in_data.op;
          if (!valid_r) begin
            ks_start = 1'b1;
            valid_nxt = 1'b1;
            pend_nxt = 1'b1;
          end else begin
            st_nxt = spc_pkg::ST_EXPAND;
          end
          rnd_nxt = in_data.op ? 6'(spc_pkg::ROUND_COUNT) : 6'd0;
          rd_addr = rnd_nxt;
        end else if (pend_r && !ks_busy) begin
          pend_nxt = 1'b0;
          st_nxt = spc_pkg::ST_EXPAND;
          rd_addr = rnd_r;
        end
      end
      spc_pkg::ST_EXPAND: begin
        // First key word arriving; start rounds
        st_nxt = spc_pkg::ST_RUN;
        if (!op_r) begin
          sb = spc_pkg::sbox_slice(rnd_r[2:0], mix, 1'b0);
          s_nxt = spc_pkg::lin_fwd(sb);
          rnd_nxt = 6'd1;
        end else begin
          s_nxt = mix;
          rnd_nxt = 6'(spc_pkg::ROUND_COUNT - 1);
        end
        rd_addr = rnd_nxt;
      end
      spc_pkg::ST_RUN: begin
        if (!op_r) begin
          sb = spc_pkg::sbox_slice(rnd_r[2:0], mix, 1'b0);
          if (rnd_r == 6'(spc_pkg::ROUND_COUNT)) begin
            s_nxt = mix;
            st_nxt = spc_pkg::ST_DONE;
          end else begin
            s_nxt = (rnd_r == 6'(spc_pkg::ROUND_COUNT - 1)) ? sb : spc_pkg::lin_fwd(sb);
          end
          rnd_nxt = rnd_r + 6'd1;
        end else begin
          sb = spc_pkg::sbox_slice(rnd_r[2:0],
                 (rnd_r == 6'(spc_pkg::ROUND_COUNT - 1)) ? s_r : spc_pkg::lin_inv(s_r), 1'b1);
          s_nxt = sb ^ rk;
          if (rnd_r == 6'd0) st_nxt = spc_pkg::ST_DONE;
          rnd_nxt = rnd_r - 6'd1;
        end
        // Keep the read address inside the store on the last round
        rd_addr = (st_nxt == spc_pkg::ST_DONE) ? rnd_r : rnd_nxt;
      end
      spc_pkg::ST_DONE: begin
        if (out_ready) st_nxt = spc_pkg::ST_IDLE;
      end
      default: st_nxt = spc_pkg::ST_IDLE;
    endcase
  end

  // Hold control and state words
  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    op_r <= op_nxt;
    rnd_r <= rnd_nxt;
    if (!rst_n) begin
      st_r <= spc_pkg::ST_IDLE;
      valid_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      valid_r <= valid_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign out_data = '{out_word0: s_r[31:0], out_word1: s_r[63:32],
                      out_word2: s_r[95:64], out_word3: s_r[127:96]};

  `ASSERT_IMPL(a_no_run_in_expand, clk, rst_n, ks_busy, st_r != spc_pkg::ST_RUN)
  `ASSERT_IMPL(a_keys_before_run, clk, rst_n, st_r == spc_pkg::ST_RUN, valid_r)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule
`default_nettype wire
